FILE: hdl/pxd_pkg.sv
// Package for the XPM palette pixel decoder.
// Holds the payload and control types, the function, kind, status and register codes
// and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package pxd_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_DEFINE = 2'd1;
  localparam logic [1:0] FUNC_PIXEL  = 2'd2;

  localparam logic [1:0] KIND_HEX  = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd1;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_HEX  = 3'd1;
  localparam logic [2:0] STAT_NO_COLOR = 3'd2;
  localparam logic [2:0] STAT_UNDEF    = 3'd3;
  localparam logic [2:0] STAT_TOO_MANY = 3'd4;

  localparam logic [1:0] REG_CPP    = 2'd0;
  localparam logic [1:0] REG_COLORS = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam int unsigned EPOCH_W = 4;
  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef struct packed {
    logic [1:0]  chars_per_pixel;
    logic [10:0] color_count;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key_first;
    logic [7:0] key_second;
    logic [1:0] color_kind;
    logic [7:0] red_high_char;
    logic [7:0] red_low_char;
    logic [7:0] green_high_char;
    logic [7:0] green_low_char;
    logic [7:0] blue_high_char;
    logic [7:0] blue_low_char;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] status;
    logic       last_pixel;
  } result_t;

  typedef struct packed {
    logic capture;
    logic quot;
    logic rem;
    logic exec;
    logic look;
    logic sweep;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic clear_wrap;
    logic sweep_last;
    logic out_busy;
  } stat_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

FILE: hdl/pxd_if.sv
// Stream interfaces for the XPM palette pixel decoder: input items and result items.
// Valid/ready channels; payload widths follow the field list of pxd_pkg.
`timescale 1ns / 1ps

interface pxd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key_first;
  logic [7:0] key_second;
  logic [1:0] color_kind;
  logic [7:0] red_high_char;
  logic [7:0] red_low_char;
  logic [7:0] green_high_char;
  logic [7:0] green_low_char;
  logic [7:0] blue_high_char;
  logic [7:0] blue_low_char;

  modport source(output valid, func, key_first, key_second, color_kind, red_high_char,
                 red_low_char, green_high_char, green_low_char, blue_high_char,
                 blue_low_char, input ready);
  modport sink(input valid, func, key_first, key_second, color_kind, red_high_char,
               red_low_char, green_high_char, green_low_char, blue_high_char,
               blue_low_char, output ready);
endinterface

interface pxd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [2:0] status;
  logic       last_pixel;

  modport source(output valid, red, green, blue, alpha, status, last_pixel, input ready);
  modport sink(input valid, red, green, blue, alpha, status, last_pixel, output ready);
endinterface

FILE: hdl/pxd_cfg.sv
// APB register file of the XPM palette pixel decoder.
// Holds chars_per_pixel, color_count, image_width and image_height; uses pxd_pkg.
`timescale 1ns / 1ps

module pxd_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pxd_pkg::cfg_t cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars_per_pixel <= 2'd1;
      cfg.color_count     <= '0;
      cfg.image_width     <= '0;
      cfg.image_height    <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        pxd_pkg::REG_CPP:    cfg.chars_per_pixel <= pwdata[1:0];
        pxd_pkg::REG_COLORS: cfg.color_count     <= pwdata[10:0];
        pxd_pkg::REG_WIDTH:  cfg.image_width     <= pwdata[11:0];
        pxd_pkg::REG_HEIGHT: cfg.image_height    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pxd_pkg::REG_CPP:    prdata = {30'd0, cfg.chars_per_pixel};
      pxd_pkg::REG_COLORS: prdata = {21'd0, cfg.color_count};
      pxd_pkg::REG_WIDTH:  prdata = {20'd0, cfg.image_width};
      pxd_pkg::REG_HEIGHT: prdata = {20'd0, cfg.image_height};
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: hdl/pxd_dp.sv
// Datapath of the XPM palette pixel decoder: key index unit, key table and palette
// memories, pixel counters and the result register. Driven by pxd_ctrl; uses pxd_pkg.
`timescale 1ns / 1ps

module pxd_dp #(
  parameter int unsigned KEY_TABLE_ENTRIES = 65536,
  parameter int unsigned PALETTE_DEPTH     = 256,
  parameter int unsigned MAX_COLORS        = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  pxd_pkg::cfg_t    cfg,
  input  pxd_pkg::item_t   item_data,
  input  pxd_pkg::cmd_t    cmd,
  output pxd_pkg::stat_t   stat,
  output pxd_pkg::result_t res_data,
  output logic             res_valid,
  input  logic             res_ready
);

  localparam int unsigned KEY_AW = $clog2(KEY_TABLE_ENTRIES);
  localparam int unsigned PIDX_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned EW     = pxd_pkg::EPOCH_W;
  localparam int unsigned KE_W   = EW + 1 + PIDX_W;
  localparam longint unsigned RECIP = (64'd1 << 32) / KEY_TABLE_ENTRIES;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PROD_W  = 16 + RECIP_W;

  pxd_pkg::item_t cur;
  logic [15:0]       key_raw;
  logic [15:0]       quot;
  logic [KEY_AW-1:0] kidx;
  logic [KEY_AW-1:0] sweep_addr;
  logic [KE_W-1:0]   key_mem [KEY_TABLE_ENTRIES];
  logic [31:0]       pal_mem [PALETTE_DEPTH];
  logic [KE_W-1:0]   key_rd;
  logic [31:0]       pal_rd;
  logic              hit;
  logic [EW-1:0]     epoch;
  logic [10:0]       next_entry;
  logic [PIDX_W-1:0] pal_wr;
  logic [11:0]       col;
  logic [11:0]       row;
  logic [2:0]        res_status;
  logic              res_last;

  logic [PROD_W-1:0] prod;
  logic [32:0]       qk;
  logic [16:0]       rem_a;
  logic [16:0]       rem_b;
  logic [10:0]       limit;
  logic [4:0]        n_rh, n_rl, n_gh, n_gl, n_bh, n_bl;
  logic              hex_bad;
  logic [31:0]       def_rgba;
  logic              def_full, def_nocolor, def_bad, def_write;
  logic [2:0]        def_status;
  logic              is_define, is_pixel, is_clear;
  logic              col_end, row_end, pix_last;

  assign prod  = PROD_W'(key_raw) * PROD_W'(RECIP);
  assign qk    = 33'(quot) * 33'(KEY_TABLE_ENTRIES);
  assign rem_a = {1'b0, key_raw} - qk[16:0];
  assign rem_b = (rem_a >= 17'(KEY_TABLE_ENTRIES)) ? rem_a - 17'(KEY_TABLE_ENTRIES) : rem_a;

  assign is_clear  = cur.func == pxd_pkg::FUNC_CLEAR;
  assign is_define = cur.func == pxd_pkg::FUNC_DEFINE;
  assign is_pixel  = cur.func == pxd_pkg::FUNC_PIXEL;

  assign limit = (cfg.color_count < 11'(MAX_COLORS)) ? cfg.color_count : 11'(MAX_COLORS);
  assign n_rh  = pxd_pkg::hex_value(cur.red_high_char);
  assign n_rl  = pxd_pkg::hex_value(cur.red_low_char);
  assign n_gh  = pxd_pkg::hex_value(cur.green_high_char);
  assign n_gl  = pxd_pkg::hex_value(cur.green_low_char);
  assign n_bh  = pxd_pkg::hex_value(cur.blue_high_char);
  assign n_bl  = pxd_pkg::hex_value(cur.blue_low_char);
  assign hex_bad = n_rh[4] | n_rl[4] | n_gh[4] | n_gl[4] | n_bh[4] | n_bl[4];
  assign def_rgba = (cur.color_kind == pxd_pkg::KIND_HEX) ?
                    {n_rh[3:0], n_rl[3:0], n_gh[3:0], n_gl[3:0], n_bh[3:0], n_bl[3:0], 8'hFF} :
                    32'd0;

  assign def_full    = next_entry >= limit;
  assign def_nocolor = cur.color_kind != pxd_pkg::KIND_HEX &&
                       cur.color_kind != pxd_pkg::KIND_NONE;
  assign def_bad     = cur.color_kind == pxd_pkg::KIND_HEX && hex_bad;
  assign def_write   = is_define && !def_full && !def_nocolor && !def_bad;

  always_comb begin
    if (def_full) begin
      def_status = pxd_pkg::STAT_TOO_MANY;
    end else if (def_nocolor) begin
      def_status = pxd_pkg::STAT_NO_COLOR;
    end else if (def_bad) begin
      def_status = pxd_pkg::STAT_BAD_HEX;
    end else begin
      def_status = pxd_pkg::STAT_OK;
    end
  end

  assign col_end  = (13'(col) + 13'd1) >= 13'(cfg.image_width);
  assign row_end  = (13'(row) + 13'd1) >= 13'(cfg.image_height);
  assign pix_last = col_end && row_end && cfg.image_width != 12'd0 && cfg.image_height != 12'd0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= item_data;
      key_raw <= (cfg.chars_per_pixel == 2'd2) ? {item_data.key_first, item_data.key_second}
                                                : {8'd0, item_data.key_first};
    end
    if (cmd.quot) begin
      quot <= 16'(prod >> 32);
    end
    if (cmd.rem) begin
      kidx <= KEY_AW'(rem_b);
    end
    if (cmd.exec) begin
      res_status <= is_define ? def_status : pxd_pkg::STAT_OK;
      res_last   <= is_pixel && pix_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      key_mem[sweep_addr] <= '0;
    end else if (cmd.exec && def_write) begin
      key_mem[kidx] <= {epoch, 1'b1, pal_wr};
    end
    if (cmd.exec && is_pixel) begin
      key_rd <= key_mem[kidx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && def_write) begin
      pal_mem[pal_wr] <= def_rgba;
    end
    if (cmd.look) begin
      pal_rd <= pal_mem[key_rd[PIDX_W-1:0]];
      hit    <= key_rd[PIDX_W] && key_rd[KE_W-1 -: EW] == epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= '0;
      next_entry <= '0;
      pal_wr     <= '0;
      col        <= '0;
      row        <= '0;
      sweep_addr <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= stat.sweep_last ? '0 : KEY_AW'(sweep_addr + 1'b1);
      end
      if (cmd.exec && is_clear) begin
        epoch      <= EW'(epoch + 1'b1);
        next_entry <= '0;
        pal_wr     <= '0;
        col        <= '0;
        row        <= '0;
      end
      if (cmd.exec && def_write) begin
        next_entry <= 11'(next_entry + 1'b1);
        if (next_entry[7:0] == 8'hFF || pal_wr == PIDX_W'(PALETTE_DEPTH - 1)) begin
          pal_wr <= '0;
        end else begin
          pal_wr <= PIDX_W'(pal_wr + 1'b1);
        end
      end
      if (cmd.exec && is_pixel) begin
        if (col_end) begin
          col <= '0;
          row <= row_end ? '0 : 12'(row + 1'b1);
        end else begin
          col <= 12'(col + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (is_pixel && hit) begin
        {res_data.red, res_data.green, res_data.blue, res_data.alpha} <= pal_rd;
      end else begin
        {res_data.red, res_data.green, res_data.blue, res_data.alpha} <= 32'd0;
      end
      res_data.status     <= (is_pixel && !hit) ? pxd_pkg::STAT_UNDEF : res_status;
      res_data.last_pixel <= res_last;
    end
  end

  assign stat.is_pixel   = is_pixel;
  assign stat.clear_wrap = is_clear && epoch == {EW{1'b1}};
  assign stat.sweep_last = sweep_addr == KEY_AW'(KEY_TABLE_ENTRIES - 1);
  assign stat.out_busy   = res_valid && !res_ready;

endmodule

FILE: hdl/pxd_ctrl.sv
// Controller of the XPM palette pixel decoder: sequences key table clearing, key
// index, execute, lookup and result load. Drives pxd_dp; uses pxd_pkg.
`timescale 1ns / 1ps

module pxd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pxd_pkg::stat_t stat,
  output pxd_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QUOT  = 3'd2;
  localparam logic [2:0] ST_REM   = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_LOOK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic       from_clear, from_clear_next;

  always_comb begin
    state_next      = state;
    from_clear_next = from_clear;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next      = from_clear ? ST_DONE : ST_IDLE;
          from_clear_next = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd.quot   = 1'b1;
        state_next = ST_REM;
      end
      ST_REM: begin
        cmd.rem    = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_pixel) begin
          state_next = ST_LOOK;
        end else if (stat.clear_wrap) begin
          state_next      = ST_SWEEP;
          from_clear_next = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      from_clear <= 1'b0;
    end else begin
      state      <= state_next;
      from_clear <= from_clear_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_QUOT)
    else $error("accepted item did not start the key index step");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.quot, cmd.rem, cmd.exec, cmd.look, cmd.sweep, cmd.load}))
    else $error("more than one datapath command at once");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !in_ready)
    else $error("input ready during key table sweep");

  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !stat.out_busy ##1 state == ST_IDLE)
    else $error("result loaded while output held");

endmodule

FILE: hdl/xpm_palette_pixel_decoder.sv
// Top level of the XPM palette pixel decoder.
// Joins pxd_cfg, pxd_ctrl and pxd_dp; uses pxd_pkg and the interfaces of pxd_if.
//
//   channel  direction  carries
//   item     in         func, key chars, color kind, six hex digit chars
//   result   out        red, green, blue, alpha, status, last_pixel
//   APB      in/out     register writes and reads, byte address 4*index
//
// Each item runs through these steps, from the transfer through the result load:
// accept, key index quotient, key index remainder, execute with key table read,
// palette read (pixels only), load of the result register.
// After reset the key table is swept entry by entry, no item taken.
// Every 16th clear retires the epoch tags with the same sweep before its result.
// A new item is taken while a result waits; its load holds until that result is taken.
`timescale 1ns / 1ps

module xpm_palette_pixel_decoder #(
  parameter int unsigned KEY_TABLE_ENTRIES = 65536,
  parameter int unsigned PALETTE_DEPTH     = 256,
  parameter int unsigned MAX_COLORS        = 1024
) (
  input  logic        clk,
  input  logic        rst,
  pxd_item_if.sink    item,
  pxd_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pxd_pkg::cfg_t    cfg;
  pxd_pkg::item_t   item_data;
  pxd_pkg::result_t res_data;
  pxd_pkg::cmd_t    cmd;
  pxd_pkg::stat_t   stat;

  assign item_data.func            = item.func;
  assign item_data.key_first       = item.key_first;
  assign item_data.key_second      = item.key_second;
  assign item_data.color_kind      = item.color_kind;
  assign item_data.red_high_char   = item.red_high_char;
  assign item_data.red_low_char    = item.red_low_char;
  assign item_data.green_high_char = item.green_high_char;
  assign item_data.green_low_char  = item.green_low_char;
  assign item_data.blue_high_char  = item.blue_high_char;
  assign item_data.blue_low_char   = item.blue_low_char;

  assign result.red        = res_data.red;
  assign result.green      = res_data.green;
  assign result.blue       = res_data.blue;
  assign result.alpha      = res_data.alpha;
  assign result.status     = res_data.status;
  assign result.last_pixel = res_data.last_pixel;

  pxd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pxd_dp #(
    .KEY_TABLE_ENTRIES (KEY_TABLE_ENTRIES),
    .PALETTE_DEPTH     (PALETTE_DEPTH),
    .MAX_COLORS        (MAX_COLORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_data (item_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_data  (res_data),
    .res_valid (result.valid),
    .res_ready (result.ready)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for xpm_palette_pixel_decoder: palette defines, pixel lookups,
// clears, register access and image counting, checked against a built-in decoder model.
// Depends on pxd_pkg, pxd_item_if and pxd_result_if.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned KEY_TABLE_ENTRIES = 65536;
  localparam int unsigned PALETTE_DEPTH     = 256;
  localparam int unsigned MAX_COLORS        = 1024;
  localparam int unsigned STALL_LIMIT       = 4 * KEY_TABLE_ENTRIES;
  localparam int unsigned SETTLE_CYCLES     = 16;
  localparam int unsigned REPORT_LIMIT      = 10;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [1:0] KIND_ABSENT   = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pxd_item_if   items();
  pxd_result_if results();

  xpm_palette_pixel_decoder #(
    .KEY_TABLE_ENTRIES(KEY_TABLE_ENTRIES),
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_COLORS(MAX_COLORS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(items),
    .result(results),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  logic [1:0]  cfg_cpp;
  logic [10:0] cfg_colors;
  logic [11:0] cfg_width;
  logic [11:0] cfg_height;
  logic [7:0]  key_map [int unsigned];
  logic [31:0] palette_rgba [PALETTE_DEPTH];
  int unsigned next_entry;
  int unsigned col_pos;
  int unsigned row_pos;

  pxd_pkg::result_t decoded_due [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned images_sent;
  int unsigned clears_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'h10;
  endfunction

  function automatic pxd_pkg::result_t decode_item(pxd_pkg::item_t it);
    pxd_pkg::result_t r;
    int unsigned key;
    int unsigned lim;
    logic [31:0] rgba;
    logic [47:0] chars;
    logic [4:0]  nib;
    bit          bad;
    bit          col_end;
    bit          row_end;
    r = '0;
    key = (cfg_cpp == 2'd2) ? {it.key_first, it.key_second} : it.key_first;
    key = key % KEY_TABLE_ENTRIES;
    case (it.func)
      pxd_pkg::FUNC_CLEAR: begin
        key_map.delete();
        next_entry = 0;
        col_pos = 0;
        row_pos = 0;
      end
      pxd_pkg::FUNC_DEFINE: begin
        lim = (cfg_colors < MAX_COLORS) ? cfg_colors : MAX_COLORS;
        if (next_entry >= lim) begin
          r.status = pxd_pkg::STAT_TOO_MANY;
        end else if (it.color_kind != pxd_pkg::KIND_HEX &&
                     it.color_kind != pxd_pkg::KIND_NONE) begin
          r.status = pxd_pkg::STAT_NO_COLOR;
        end else begin
          rgba = '0;
          bad = 1'b0;
          if (it.color_kind == pxd_pkg::KIND_HEX) begin
            chars = {it.red_high_char, it.red_low_char, it.green_high_char,
                     it.green_low_char, it.blue_high_char, it.blue_low_char};
            for (int i = 0; i < 6; i++) begin
              nib = nibble_of(chars[47 - 8 * i -: 8]);
              bad |= nib[4];
              rgba[31 - 4 * i -: 4] = nib[3:0];
            end
            rgba[7:0] = 8'hFF;
          end
          if (bad) begin
            r.status = pxd_pkg::STAT_BAD_HEX;
          end else begin
            palette_rgba[(next_entry % 256) % PALETTE_DEPTH] = rgba;
            key_map[key] = 8'(next_entry % 256);
            next_entry = (next_entry + 1) % 2048;
          end
        end
      end
      pxd_pkg::FUNC_PIXEL: begin
        if (key_map.exists(key)) begin
          {r.red, r.green, r.blue, r.alpha} = palette_rgba[key_map[key] % PALETTE_DEPTH];
        end else begin
          r.status = pxd_pkg::STAT_UNDEF;
        end
        col_end = (col_pos + 1 >= cfg_width);
        row_end = (row_pos + 1 >= cfg_height);
        r.last_pixel = col_end && row_end && cfg_width != 0 && cfg_height != 0;
        if (col_end) begin
          col_pos = 0;
          row_pos = row_end ? 0 : (row_pos + 1) % 4096;
        end else begin
          col_pos = (col_pos + 1) % 4096;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] register_value(logic [1:0] idx);
    case (idx)
      pxd_pkg::REG_CPP:    return 32'(cfg_cpp);
      pxd_pkg::REG_COLORS: return 32'(cfg_colors);
      pxd_pkg::REG_WIDTH:  return 32'(cfg_width);
      default:             return 32'(cfg_height);
    endcase
  endfunction

  function automatic pxd_pkg::item_t random_fields();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return pxd_pkg::item_t'(bits[$bits(pxd_pkg::item_t)-1:0]);
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned n;
    n = $urandom_range(21);
    if (n < 10) return "0" + 8'(n);
    if (n < 16) return "a" + 8'(n - 10);
    return "A" + 8'(n - 16);
  endfunction

  function automatic logic [47:0] rand_hex();
    logic [47:0] s;
    for (int i = 0; i < 6; i++) s[8 * i +: 8] = hex_char();
    return s;
  endfunction

  function automatic pxd_pkg::item_t define_item(logic [7:0] k1, logic [7:0] k2,
                                                 logic [1:0] kind, logic [47:0] hex);
    pxd_pkg::item_t it;
    it = random_fields();
    it.func = pxd_pkg::FUNC_DEFINE;
    it.key_first = k1;
    it.key_second = k2;
    it.color_kind = kind;
    {it.red_high_char, it.red_low_char, it.green_high_char, it.green_low_char,
     it.blue_high_char, it.blue_low_char} = hex;
    return it;
  endfunction

  function automatic pxd_pkg::item_t random_define(logic [7:0] k1, logic [7:0] k2);
    int unsigned pick;
    int unsigned pos;
    logic [47:0] hex;
    logic [1:0]  kind;
    pick = $urandom_range(99);
    hex = rand_hex();
    kind = pxd_pkg::KIND_HEX;
    if (pick >= 80 && pick < 88) begin
      kind = pxd_pkg::KIND_NONE;
      hex = 48'({$urandom, $urandom});
    end else if (pick >= 88 && pick < 94) begin
      kind = pick[0] ? KIND_ABSENT : KIND_RESERVED;
    end else if (pick >= 94) begin
      pos = $urandom_range(5);
      hex[8 * pos +: 8] = 8'($urandom_range(255));
    end
    return define_item(k1, k2, kind, hex);
  endfunction

  function automatic pxd_pkg::item_t pixel_item(logic [7:0] k1, logic [7:0] k2);
    pxd_pkg::item_t it;
    it = random_fields();
    it.func = pxd_pkg::FUNC_PIXEL;
    it.key_first = k1;
    it.key_second = k2;
    return it;
  endfunction

  function automatic pxd_pkg::item_t func_item(logic [1:0] func);
    pxd_pkg::item_t it;
    it = random_fields();
    it.func = func;
    return it;
  endfunction

  task automatic push_item(pxd_pkg::item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    items.valid           <= 1'b1;
    items.func            <= it.func;
    items.key_first       <= it.key_first;
    items.key_second      <= it.key_second;
    items.color_kind      <= it.color_kind;
    items.red_high_char   <= it.red_high_char;
    items.red_low_char    <= it.red_low_char;
    items.green_high_char <= it.green_high_char;
    items.green_low_char  <= it.green_low_char;
    items.blue_high_char  <= it.blue_high_char;
    items.blue_low_char   <= it.blue_low_char;
    do @(posedge clk); while (!items.ready);
    decoded_due.push_back(decode_item(it));
    if (it.func != FUNC_UNUSED) items_sent++;
    if (it.func == pxd_pkg::FUNC_CLEAR) clears_sent++;
  endtask

  task automatic settle();
    items.valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      pxd_pkg::REG_CPP:    cfg_cpp = value[1:0];
      pxd_pkg::REG_COLORS: cfg_colors = value[10:0];
      pxd_pkg::REG_WIDTH:  cfg_width = value[11:0];
      default:             cfg_height = value[11:0];
    endcase
  endtask

  task automatic check_reg(logic [1:0] idx);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== register_value(idx)) begin
      if (mismatches < REPORT_LIMIT)
        $display("register %0d read: expected %0h, got %0h", idx, register_value(idx), got);
      mismatches++;
    end
  endtask

  task automatic set_config(logic [1:0] cpp, logic [10:0] colors, logic [11:0] width,
                            logic [11:0] height);
    write_reg(pxd_pkg::REG_CPP, 32'(cpp));
    write_reg(pxd_pkg::REG_COLORS, 32'(colors));
    write_reg(pxd_pkg::REG_WIDTH, 32'(width));
    write_reg(pxd_pkg::REG_HEIGHT, 32'(height));
  endtask

  task automatic check_all_regs();
    check_reg(pxd_pkg::REG_CPP);
    check_reg(pxd_pkg::REG_COLORS);
    check_reg(pxd_pkg::REG_WIDTH);
    check_reg(pxd_pkg::REG_HEIGHT);
  endtask

  task automatic test_register_access();
    settle();
    check_all_regs();
    set_config(2'd3, 11'h7FF, 12'hFFF, 12'hFFF);
    check_all_regs();
    set_config(2'd0, 11'd0, 12'd0, 12'd0);
    check_all_regs();
  endtask

  task automatic test_single_char_keys();
    settle();
    set_config(2'd1, 11'd3, 12'd3, 12'd2);
    images_sent++;
    push_item(func_item(pxd_pkg::FUNC_CLEAR));
    push_item(define_item("a", 8'h00, pxd_pkg::KIND_HEX, "000000"));
    push_item(define_item("b", 8'hFF, pxd_pkg::KIND_HEX, "fFaA9F"));
    push_item(define_item("c", 8'h5A, pxd_pkg::KIND_NONE, {8'hFF, 40'hA5_5A_FF_00_C3}));
    push_item(define_item("d", 8'h00, KIND_ABSENT, "123456"));
    push_item(define_item("d", 8'h00, KIND_RESERVED, "123456"));
    push_item(define_item("e", 8'h00, pxd_pkg::KIND_HEX, "12g456"));
    push_item(define_item("e", 8'h00, pxd_pkg::KIND_HEX, "@:/`G0"));
    push_item(define_item("e", 8'h00, pxd_pkg::KIND_HEX, {8'hFF, "23456"}));
    push_item(define_item("f", 8'h00, pxd_pkg::KIND_HEX, "ABCDEF"));
    push_item(func_item(FUNC_UNUSED));
    push_item(pixel_item("a", 8'h00));
    push_item(pixel_item("b", 8'hFF));
    push_item(pixel_item("c", 8'h00));
    push_item(pixel_item("z", 8'h00));
    push_item(pixel_item("b", 8'h00));
    push_item(pixel_item("a", 8'h00));
  endtask

  task automatic test_two_char_keys();
    settle();
    set_config(2'd2, 11'd2, 12'd0, 12'd5);
    images_sent++;
    push_item(func_item(pxd_pkg::FUNC_CLEAR));
    push_item(define_item("a", "b", pxd_pkg::KIND_HEX, "FFFFFF"));
    push_item(define_item("a", "b", pxd_pkg::KIND_HEX, "123456"));
    push_item(pixel_item("a", "b"));
    push_item(pixel_item("a", "c"));
    push_item(pixel_item(8'h00, 8'h00));
    push_item(pixel_item("a", "b"));
  endtask

  task automatic test_palette_wrap();
    settle();
    set_config(2'd1, 11'h7FF, 12'd8, 12'd4);
    images_sent++;
    push_item(func_item(pxd_pkg::FUNC_CLEAR));
    repeat (MAX_COLORS + 6)
      push_item(define_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                            pxd_pkg::KIND_HEX, rand_hex()));
    repeat (32) push_item(pixel_item(8'($urandom_range(255)), 8'($urandom_range(255))));
  endtask

  task automatic test_random_images(int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned n_def;
    int unsigned n_pix;
    logic [1:0]  cpp;
    logic [10:0] colors;
    logic [11:0] dims [2];
    logic [15:0] k;
    logic [15:0] used_keys [$];
    start = items_sent;
    while (items_sent - start < budget) begin
      settle();
      pick = $urandom_range(99);
      cpp = (pick < 45) ? 2'd1 : (pick < 90) ? 2'd2 : (pick[0] ? 2'd3 : 2'd0);
      pick = $urandom_range(99);
      colors = (pick < 75) ? 11'($urandom_range(1, 12)) : (pick < 83) ? 11'd0 :
               (pick < 92) ? 11'h7FF : 11'd1024;
      for (int d = 0; d < 2; d++) begin
        pick = $urandom_range(99);
        dims[d] = (pick < 80) ? 12'($urandom_range(1, 8)) : (pick < 88) ? 12'd0 :
                  (pick < 94) ? 12'hFFF : 12'($urandom_range(9, 4095));
      end
      set_config(cpp, colors, dims[0], dims[1]);
      images_sent++;
      used_keys.delete();
      push_item(func_item(pxd_pkg::FUNC_CLEAR));
      n_def = (colors > 14) ? $urandom_range(4, 14) : colors + $urandom_range(0, 2);
      repeat (n_def) begin
        if (used_keys.size() != 0 && $urandom_range(99) < 10)
          k = used_keys[$urandom_range(used_keys.size() - 1)];
        else
          k = 16'($urandom);
        used_keys.push_back(k);
        push_item(random_define(k[15:8], k[7:0]));
      end
      if (dims[0] != 0 && dims[0] <= 8 && dims[1] != 0 && dims[1] <= 8)
        n_pix = dims[0] * dims[1] + (($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
      else
        n_pix = $urandom_range(10, 30);
      repeat (n_pix) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          push_item(func_item(FUNC_UNUSED));
        end else if (pick < 8) begin
          push_item(random_define(8'($urandom_range(255)), 8'($urandom_range(255))));
        end
        if (used_keys.size() != 0 && $urandom_range(99) < 85) begin
          k = used_keys[$urandom_range(used_keys.size() - 1)];
          if (cpp != 2'd2) k[7:0] = 8'($urandom_range(255));
        end else begin
          k = 16'($urandom);
        end
        push_item(pixel_item(k[15:8], k[7:0]));
      end
    end
  endtask

  task automatic check_result();
    pxd_pkg::result_t got;
    pxd_pkg::result_t want;
    got.red        = results.red;
    got.green      = results.green;
    got.blue       = results.blue;
    got.alpha      = results.alpha;
    got.status     = results.status;
    got.last_pixel = results.last_pixel;
    results_checked++;
    if (decoded_due.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("result with nothing pending: rgba=%02h%02h%02h%02h status=%0d last=%0d",
                 got.red, got.green, got.blue, got.alpha, got.status, got.last_pixel);
      mismatches++;
    end else begin
      want = decoded_due.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.status !== want.status ||
          got.last_pixel !== want.last_pixel) begin
        if (mismatches < REPORT_LIMIT)
          $display("result %0d: expected rgba=%02h%02h%02h%02h status=%0d last=%0d, ",
                   results_checked, want.red, want.green, want.blue, want.alpha,
                   want.status, want.last_pixel,
                   "got rgba=%02h%02h%02h%02h status=%0d last=%0d",
                   got.red, got.green, got.blue, got.alpha, got.status, got.last_pixel);
        mismatches++;
      end
    end
  endtask

  initial begin : result_sink
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results.valid && results.ready) check_result();
      results.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((items.valid && items.ready) || (results.valid && results.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    items.valid           <= 1'b0;
    items.func            <= pxd_pkg::FUNC_CLEAR;
    items.key_first       <= '0;
    items.key_second      <= '0;
    items.color_kind      <= pxd_pkg::KIND_HEX;
    items.red_high_char   <= '0;
    items.red_low_char    <= '0;
    items.green_high_char <= '0;
    items.green_low_char  <= '0;
    items.blue_high_char  <= '0;
    items.blue_low_char   <= '0;
    cfg_cpp = 2'd1;
    cfg_colors = '0;
    cfg_width = '0;
    cfg_height = '0;
    for (int i = 0; i < PALETTE_DEPTH; i++) palette_rgba[i] = '0;
    next_entry = 0;
    col_pos = 0;
    row_pos = 0;
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    images_sent = 0;
    clears_sent = 0;
    send_idle_pct = 14;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_single_char_keys();
    test_two_char_keys();
    test_palette_wrap();
    test_random_images(150);
    send_idle_pct = 77;
    recv_idle_pct = 14;
    test_random_images(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_images(150);
    settle();
    mismatches += decoded_due.size();

    $display("Decoded %0d items over %0d images and %0d clears; %0d results checked,",
             items_sent, images_sent, clears_sent, results_checked);
    $display("register readback and three sender/receiver stall mixes included.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pxd_pkg.sv
hdl/pxd_if.sv
hdl/pxd_cfg.sv
hdl/pxd_dp.sv
hdl/pxd_ctrl.sv
hdl/xpm_palette_pixel_decoder.sv
tb/tb_top.sv
